// ----- rtl/rvg_pkg.sv -----
// Shared constants, register indexes and a helper function for the radial vignette gain block.
package rvg_pkg;

  localparam int unsigned COORD_BITS_DEF     = 14;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CENTER_W   = 22;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned NUM_K      = 5;
  localparam int unsigned ACC_W      = 40;
  // 11-bit half significand times 32-bit gain magnitude
  localparam int unsigned BIG_W      = 43;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 4'd0,
    CFG_CENTER_Y   = 4'd1,
    CFG_INV_RADIUS = 4'd2,
    CFG_GAIN_K1    = 4'd3,
    CFG_GAIN_K2    = 4'd4,
    CFG_GAIN_K3    = 4'd5,
    CFG_GAIN_K4    = 4'd6,
    CFG_GAIN_K5    = 4'd7
  } cfg_idx_e;

  localparam logic [HALF_W-1:0] HALF_QNAN = 16'h7E00;
  localparam logic [HALF_W-2:0] HALF_INF  = 15'h7C00;

  // position of the highest set bit, 0 for a zero word
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ----- rtl/radial_vignette_gain_core.sv -----
// Radial vignette gain correction of one half-float pixel per clock.
//
// A fully pipelined datapath: one pixel word enters per clock while the output
// side does not stall. The pipeline runs through the chain of 32x32 multiplies
// that build r2 and its powers (two stages per power) and then four stages of
// half-float scaling, which scale channels 0 to 2; channel 3 passes through
// unscaled. A stall on the output freezes the whole pipeline, so throughput is
// one word per cycle whenever out_stall_i is low. Registers are written through
// the cfg port (always ready) and must only change while the pipeline is empty.
module radial_vignette_gain_core
  import rvg_pkg::*;
#(
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pixel_col_i,
  input  logic [COORD_BITS-1:0] pixel_row_i,
  input  logic [HALF_W-1:0]     chan_in_0_i,
  input  logic [HALF_W-1:0]     chan_in_1_i,
  input  logic [HALF_W-1:0]     chan_in_2_i,
  input  logic [HALF_W-1:0]     chan_in_3_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [HALF_W-1:0]     chan_out_0_o,
  output logic [HALF_W-1:0]     chan_out_1_o,
  output logic [HALF_W-1:0]     chan_out_2_o,
  output logic [HALF_W-1:0]     chan_out_3_o
);

  localparam int unsigned POS_W  = COORD_BITS + 8;
  localparam int unsigned MAG_W  = (POS_W > CENTER_W) ? POS_W : CENTER_W;
  localparam int unsigned PROD_W = MAG_W + 32;
  localparam int unsigned NS     = 20;
  localparam int unsigned ST_G   = 15;
  localparam int unsigned ST_H1  = 16;
  localparam logic signed [7:0] E_SUB = 8'(24 + GAIN_FRAC_BITS);
  localparam logic signed [7:0] E_OFS = 8'(25 + GAIN_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(64'd1 << GAIN_FRAC_BITS);

  typedef logic [HALF_W-1:0] chans_t [4];

  // configuration registers
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [31:0]         inv_radius_q;
  logic signed [31:0]  gain_k_q [NUM_K];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      inv_radius_q <= '0;
      for (int i = 0; i < NUM_K; i++) gain_k_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_X:   center_x_q   <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_Y:   center_y_q   <= cfg_data_i[CENTER_W-1:0];
        CFG_INV_RADIUS: inv_radius_q <= cfg_data_i;
        CFG_GAIN_K1:    gain_k_q[0]  <= cfg_data_i;
        CFG_GAIN_K2:    gain_k_q[1]  <= cfg_data_i;
        CFG_GAIN_K3:    gain_k_q[2]  <= cfg_data_i;
        CFG_GAIN_K4:    gain_k_q[3]  <= cfg_data_i;
        CFG_GAIN_K5:    gain_k_q[4]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the whole pipe holds while the output word is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [NS-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end
  assign out_valid_o = v_q[NS-1];

  // channel delay line
  chans_t pix_q [NS];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[0][0] <= chan_in_0_i;
      pix_q[0][1] <= chan_in_1_i;
      pix_q[0][2] <= chan_in_2_i;
      pix_q[0][3] <= chan_in_3_i;
      for (int k = 1; k < NS; k++) pix_q[k] <= pix_q[k-1];
    end
  end

  // stage 0: distance from center in Q.8
  logic [MAG_W-1:0] pos_x, pos_y, cx, cy, mag_x_q, mag_y_q;
  assign pos_x = MAG_W'({pixel_col_i, 8'd0});
  assign pos_y = MAG_W'({pixel_row_i, 8'd0});
  assign cx    = MAG_W'(center_x_q);
  assign cy    = MAG_W'(center_y_q);

  // stage 1: scale by reciprocal radius
  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  // stage 2: normalized offsets, Q.30
  logic [PROD_W:0] nxr, nyr;
  logic [31:0]     nx_q, ny_q;
  // stage 3: squares
  logic [63:0]     sq_x_q, sq_y_q;
  // stage 4: r2
  logic [64:0]     r2_sum;
  logic [31:0]     r2_q;

  assign nxr    = {1'b0, prod_x_q} + (PROD_W+1)'(128);
  assign nyr    = {1'b0, prod_y_q} + (PROD_W+1)'(128);
  assign r2_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q} + 65'(1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_x_q  <= (pos_x >= cx) ? pos_x - cx : cx - pos_x;
      mag_y_q  <= (pos_y >= cy) ? pos_y - cy : cy - pos_y;
      prod_x_q <= PROD_W'(mag_x_q) * PROD_W'(inv_radius_q);
      prod_y_q <= PROD_W'(mag_y_q) * PROD_W'(inv_radius_q);
      // clamp at 2.0
      if ((nxr[PROD_W:40] != '0) || (nxr[39] && nxr[38:8] != '0)) nx_q <= 32'h8000_0000;
      else                                                        nx_q <= nxr[39:8];
      if ((nyr[PROD_W:40] != '0) || (nyr[39] && nyr[38:8] != '0)) ny_q <= 32'h8000_0000;
      else                                                        ny_q <= nyr[39:8];
      sq_x_q   <= 64'(nx_q) * 64'(nx_q);
      sq_y_q   <= 64'(ny_q) * 64'(ny_q);
      r2_q     <= (r2_sum[64:62] != '0) ? 32'hFFFF_FFFF : r2_sum[61:30];
    end
  end

  // stages 5..14: one multiply stage and one round stage per coefficient
  logic signed [64:0]      tm_q  [NUM_K];
  logic [63:0]             mm_q  [NUM_K];
  logic [31:0]             rm_q  [NUM_K];
  logic signed [ACC_W-1:0] am_q  [NUM_K];
  logic [31:0]             pw_q  [NUM_K];
  logic [31:0]             r2c_q [NUM_K];
  logic signed [ACC_W-1:0] acc_q [NUM_K];

  for (genvar i = 0; i < NUM_K; i++) begin : g_pow
    logic [31:0]             p_in, r_in;
    logic signed [ACC_W-1:0] a_in;
    logic [63:0]             t_mag;
    logic [64:0]             t_rnd, m_rnd;
    logic signed [ACC_W-1:0] term;

    if (i == 0) begin : g_first
      assign p_in = r2_q;
      assign r_in = r2_q;
      assign a_in = ACC_ONE;
    end else begin : g_next
      assign p_in = pw_q[i-1];
      assign r_in = r2c_q[i-1];
      assign a_in = acc_q[i-1];
    end

    // round half away from zero
    assign t_mag = tm_q[i][64] ? 64'(-tm_q[i]) : 64'(tm_q[i]);
    assign t_rnd = {1'b0, t_mag} + 65'(1 << 29);
    assign term  = tm_q[i][64] ? -ACC_W'(t_rnd[64:30]) : ACC_W'(t_rnd[64:30]);
    assign m_rnd = {1'b0, mm_q[i]} + 65'(1 << 29);

    always_ff @(posedge clk_i) begin
      if (en) begin
        tm_q[i]  <= 65'(gain_k_q[i]) * $signed({33'd0, p_in});
        mm_q[i]  <= 64'(p_in) * 64'(r_in);
        rm_q[i]  <= r_in;
        am_q[i]  <= a_in;
        acc_q[i] <= am_q[i] + term;
        pw_q[i]  <= (m_rnd[64:62] != '0) ? 32'hFFFF_FFFF : m_rnd[61:30];
        r2c_q[i] <= rm_q[i];
      end
    end
  end

  // stage 15: saturated gain, split into sign and magnitude
  logic        gs_q, gz_q;
  logic [31:0] gm_q;
  logic [4:0]  lg_q;
  logic signed [31:0] gain_sat;
  logic [31:0] gm_d;

  always_comb begin
    if (acc_q[NUM_K-1] > ACC_W'(32'sh7FFF_FFFF))       gain_sat = 32'sh7FFF_FFFF;
    else if (acc_q[NUM_K-1] < -ACC_W'(33'sh8000_0000)) gain_sat = 32'sh8000_0000;
    else                                               gain_sat = acc_q[NUM_K-1][31:0];
    gm_d = gain_sat[31] ? 32'(-gain_sat) : 32'(gain_sat);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gs_q <= gain_sat[31];
      gm_q <= gm_d;
      gz_q <= (gm_d == '0);
      lg_q <= msb_pos(gm_d);
    end
  end

  // stages 16..19: half-float scaling per scaled channel (0 to 2)
  logic [HALF_W-1:0] res [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [HALF_W-1:0] h;
    logic [10:0]       m;
    logic [4:0]        ex;
    logic [3:0]        lm;

    // H1
    logic [BIG_W-1:0]  big1_q;
    logic [5:0]        guess_q;
    logic signed [7:0] e1_q;
    logic              nan1_q, inf1_q, sg1_q, gz1_q;
    logic [HALF_W-1:0] h1_q;
    // H2
    logic [5:0]        n;
    logic signed [7:0] u, um;
    logic [BIG_W-1:0]  big2_q;
    logic signed [7:0] s2_q, um2_q;
    logic              nan2_q, inf2_q, sg2_q, gz2_q, zero2_q, ovf2_q;
    logic [HALF_W-1:0] h2_q;
    // H3
    logic [BIG_W-1:0]  sh, low_mask;
    logic [5:0]        sp;
    logic [11:0]       mant_d, mant3_q;
    logic signed [7:0] um3_q;
    logic              nan3_q, inf3_q, sg3_q, gz3_q, zero3_q, ovf3_q;
    logic [HALF_W-1:0] h3_q;
    // H4
    logic [15:0]       total;
    logic [HALF_W-1:0] out_q;

    assign h  = pix_q[ST_G][c];
    assign ex = h[14:10];
    assign m  = (ex == '0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    assign lm = 4'(msb_pos(32'(m)));

    always_ff @(posedge clk_i) begin
      if (en) begin
        big1_q  <= BIG_W'(m) * BIG_W'(gm_q);
        guess_q <= 6'(lm) + 6'(lg_q);
        e1_q    <= (ex == '0) ? -E_SUB : $signed({3'b000, ex}) - E_OFS;
        nan1_q  <= (ex == 5'd31) && (h[9:0] != '0);
        inf1_q  <= (ex == 5'd31) && (h[9:0] == '0);
        sg1_q   <= h[15] ^ gs_q;
        gz1_q   <= gz_q;
        h1_q    <= h;
      end
    end

    // leading one sits at the guess or one above it
    assign n  = ((big1_q >> (guess_q + 6'd1)) != '0) ? guess_q + 6'd1 : guess_q;
    assign u  = $signed({2'b00, n}) + e1_q;
    assign um = (u < -8'sd14) ? -8'sd14 : u;

    always_ff @(posedge clk_i) begin
      if (en) begin
        big2_q  <= big1_q;
        s2_q    <= um - 8'sd10 - e1_q;
        um2_q   <= um;
        ovf2_q  <= (u > 8'sd15);
        zero2_q <= (big1_q == '0);
        nan2_q  <= nan1_q;
        inf2_q  <= inf1_q;
        sg2_q   <= sg1_q;
        gz2_q   <= gz1_q;
        h2_q    <= h1_q;
      end
    end

    // shift to the half precision, round to nearest even
    assign sp       = s2_q[5:0];
    assign sh       = big2_q >> sp;
    assign low_mask = (BIG_W'(1) << (sp - 6'd1)) - BIG_W'(1);

    always_comb begin
      if (s2_q <= 8'sd0) begin
        mant_d = 12'(big2_q << 6'(-s2_q));
      end else if (s2_q >= 8'sd44) begin
        mant_d = '0;
      end else if (big2_q[6'(sp - 6'd1)] && (((big2_q & low_mask) != '0) || sh[0])) begin
        mant_d = 12'(sh) + 12'd1;
      end else begin
        mant_d = 12'(sh);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mant3_q <= mant_d;
        um3_q   <= um2_q;
        ovf3_q  <= ovf2_q;
        zero3_q <= zero2_q;
        nan3_q  <= nan2_q;
        inf3_q  <= inf2_q;
        sg3_q   <= sg2_q;
        gz3_q   <= gz2_q;
        h3_q    <= h2_q;
      end
    end

    assign total = 16'(mant3_q) + (16'(unsigned'(um3_q + 8'sd14)) << 10);

    always_ff @(posedge clk_i) begin
      if (en) begin
        priority if (nan3_q)   out_q <= h3_q;
        else if (inf3_q)       out_q <= gz3_q ? HALF_QNAN : {sg3_q, HALF_INF};
        else if (zero3_q)      out_q <= {sg3_q, 15'd0};
        else if (ovf3_q || total >= 16'h7C00) out_q <= {sg3_q, HALF_INF};
        else                   out_q <= {sg3_q, total[14:0]};
      end
    end

    assign res[c] = out_q;
  end

  assign chan_out_0_o = res[0];
  assign chan_out_1_o = res[1];
  assign chan_out_2_o = res[2];
  assign chan_out_3_o = pix_q[NS-1][3];

endmodule

// ----- rtl/rvg_checker.sv -----
// Port-level checks for the radial vignette gain core, bound to the top level.
module rvg_port_checks
  import rvg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [HALF_W-1:0] chan_out_0_o,
  input logic [HALF_W-1:0] chan_out_3_o
);

  // hold the word while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(chan_out_0_o) && $stable(chan_out_3_o))
    else $error("output word changed under stall");

  // the input side stalls exactly when the output word is blocked
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output blockage");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

endmodule

bind radial_vignette_gain_core rvg_port_checks u_rvg_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .chan_out_0_o (chan_out_0_o),
  .chan_out_3_o (chan_out_3_o)
);
